// ===== src/rlb_pkg.sv =====
// shared types and constants for the radial light burst frame unit
// no dependencies; imported by rlb_ram users, rlb_math and the top level
package rlb_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_SAMPLES = 20;

    localparam int COORD_W  = 8;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int ADDR_W   = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int N_W      = $clog2(MAX_SAMPLES + 1);
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 3;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int ROOT_W     = 16;
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 16;

    localparam int AMOUNT_MIN   = 655;
    localparam int PERCENT_DIV  = 100;
    localparam int CENTER_PAD   = 16;

    // ceil(2^30 / 100), exact for dividends below 2^23
    localparam int RECIP_100    = 10737419;
    localparam int RECIP_SHIFT  = 30;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd5;

    typedef enum logic {
        MATH_DIV,
        MATH_SQRT
    } math_op_t;

    typedef struct packed {
        logic                  start;
        math_op_t              op;
        logic [DIVIDEND_W-1:0] a;
        logic [DIVISOR_W-1:0]  b;
    } math_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
        logic [DIVISOR_W-1:0]  rem;
        logic [ROOT_W-1:0]     root;
    } math_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT_D,
        ST_SQRT_M,
        ST_FALLOFF,
        ST_SCALE,
        ST_AMOUNT,
        ST_CHECK,
        ST_STEP_X,
        ST_STEP_Y,
        ST_SAMP_RD,
        ST_SAMP_ACC,
        ST_PIX_RD,
        ST_PIX_WAIT,
        ST_CH_MUL,
        ST_CH_DIV,
        ST_FINISH
    } state_t;

endpackage

// ===== src/rlb_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module rlb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/rlb_math.sv =====
// shared iterative unit: restoring divide (one bit a cycle) and square root
// (one root bit a cycle); depends on rlb_pkg
module rlb_math (
    input  logic               clk,
    input  logic               rst_n,
    input  rlb_pkg::math_req_t req,
    output rlb_pkg::math_rsp_t rsp
);
    import rlb_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    math_op_t              op_reg, op_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [19:0]           rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [19:0] div_trial, sq_trial, sq_test;
    logic        div_ge, sq_ge, last;

    assign div_trial = {rem_reg[18:0], work_reg[DIVIDEND_W-1]};
    assign div_ge    = div_trial >= {4'b0, dvs_reg};
    assign sq_trial  = {rem_reg[17:0], work_reg[DIVIDEND_W-1 -: 2]};
    assign sq_test   = {2'b0, root_reg, 2'b01};
    assign sq_ge     = sq_trial >= sq_test;
    assign last      = (op_reg == MATH_DIV) ? (cnt_reg == 5'(DIV_STEPS - 1))
                                            : (cnt_reg == 5'(SQRT_STEPS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        root_next = root_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            rem_next  = '0;
            work_next = req.a;
            root_next = '0;
            dvs_next  = req.b;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (op_reg == MATH_DIV)
            begin
                rem_next  = div_ge ? (div_trial - {4'b0, dvs_reg}) : div_trial;
                work_next = {work_reg[DIVIDEND_W-2:0], div_ge};
            end
            else
            begin
                rem_next  = sq_ge ? (sq_trial - sq_test) : sq_trial;
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                work_next = {work_reg[DIVIDEND_W-3:0], 2'b00};
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= MATH_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        root_reg <= root_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = work_reg;
    assign rsp.rem  = rem_reg[DIVISOR_W-1:0];
    assign rsp.root = root_reg;

endmodule

// ===== src/radial_light_burst_frame_unit.sv =====
// top level: frame store, config registers and the per-pixel sequencer
// depends on rlb_pkg, rlb_ram, rlb_math
//
// channel | signals                      | moves
// --------+------------------------------+----------------------------------
// in      | in_valid / in_stall          | load or process beat
// out     | out_valid / out_stall        | processed pixel beat
// cfg     | cfg_write, cfg_index, data   | register write, no handshake
//
// a load beat is written while idle and leaves the unit ready for the next one;
// a process beat runs through the shared one-bit-a-cycle divide/root unit (two
// roots, up to six divides) and the single store port; it skips the falloff
// divide beyond the radius and the sample and channel steps with no light.
// reset presets only control and config; the store holds no data until loaded.
// out_stall holds the result in its register while loads go on; a process beat
// waits at its end for the register to free
module radial_light_burst_frame_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [rlb_pkg::COORD_W-1:0]     pixel_x,
    input  logic [rlb_pkg::COORD_W-1:0]     pixel_y,
    input  logic [rlb_pkg::CHAN_W-1:0]      red_in,
    input  logic [rlb_pkg::CHAN_W-1:0]      green_in,
    input  logic [rlb_pkg::CHAN_W-1:0]      blue_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rlb_pkg::COORD_W-1:0]     out_x,
    output logic [rlb_pkg::COORD_W-1:0]     out_y,
    output logic [rlb_pkg::CHAN_W-1:0]      red_out,
    output logic [rlb_pkg::CHAN_W-1:0]      green_out,
    output logic [rlb_pkg::CHAN_W-1:0]      blue_out,
    output logic                            brightened,
    input  logic                            cfg_write,
    input  logic [rlb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlb_pkg::CFG_W-1:0]       cfg_data
);
    import rlb_pkg::*;

    // config
    logic [12:0] cx_reg, cy_reg;
    logic [6:0]  int_reg;
    logic [8:0]  ray_reg, fw_reg, fh_reg;

    // control
    state_t state_reg, state_next;
    logic   launched_reg, launched_next;
    logic   out_valid_reg, out_valid_next;

    // datapath
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [28:0]        sqd_reg;
    logic [26:0]        sqm_reg;
    logic [N_W-1:0]     n_reg;
    logic [13:0]        d_reg, denom_reg;
    logic [16:0]        falloff_reg, amount_reg;
    logic [23:0]        amt_num_reg;
    logic               bright_reg;
    logic signed [13:0] ax_reg, ay_reg, qx_reg, qy_reg;
    logic [8:0]         bx_reg, by_reg;
    logic [9:0]         rx_reg, ry_reg;
    logic [N_W-1:0]     samp_cnt_reg;
    logic [15:0]        sum_reg [3];
    logic [CHAN_W-1:0]  new_reg [3];
    logic [1:0]         chan_reg;
    logic [32:0]        prod_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [PIX_W-1:0]   out_pix_reg;
    logic               out_bright_reg;

    // ram and math
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;
    math_req_t         math_req;
    math_rsp_t         math_rsp;

    logic in_accept, out_free, math_state;

    // derived values
    logic [N_W-1:0]     n_val;
    logic [7:0]         ew_m1, eh_m1, wtot;
    logic [10:0]        n_prod;
    logic [8:0]         unit16n;
    logic signed [13:0] dx_w, dy_w, sel_d;
    logic signed [27:0] dx_sq, dy_sq;
    logic [14:0]        mag_2d;
    logic               d_neg;
    logic [9:0]         div_q;
    logic [8:0]         div_r;
    logic signed [13:0] a_val;
    logic [8:0]         b_val;
    logic [9:0]         rx_sum, ry_sum;
    logic               cx_carry, cy_carry;
    logic [7:0]         sx, sy;
    logic [N_W-1:0]     weight;
    logic [CHAN_W:0]    ch_sum;
    logic [CHAN_W-1:0]  ch_sat;
    logic [47:0]        amt_prod;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign n_val   = (ray_reg[8:2] > 7'(MAX_SAMPLES)) ? N_W'(MAX_SAMPLES) : ray_reg[2 +: N_W];
    assign ew_m1   = (fw_reg == 9'd0) ? 8'd0 : (fw_reg > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH - 1)
                                     : 8'(fw_reg - 9'd1);
    assign eh_m1   = (fh_reg == 9'd0) ? 8'd0 : (fh_reg > 9'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT - 1)
                                     : 8'(fh_reg - 9'd1);
    assign n_prod  = 11'(n_reg * ({1'b0, n_reg} + 6'd1));
    assign wtot    = n_prod[8:1];
    assign unit16n = {n_reg, 4'b0};

    // divide by 100 through a reciprocal
    assign amt_prod = {24'b0, amt_num_reg} * 48'(RECIP_100);

    assign dx_w  = $signed({2'b0, x_reg, 4'b0}) - $signed({1'b0, cx_reg});
    assign dy_w  = $signed({2'b0, y_reg, 4'b0}) - $signed({1'b0, cy_reg});
    assign dx_sq = dx_w * dx_w;
    assign dy_sq = dy_w * dy_w;

    // signed floor split of twice the offset by 16*N
    assign sel_d  = (state_reg == ST_STEP_X) ? dx_w : dy_w;
    assign d_neg  = sel_d[13];
    assign mag_2d = d_neg ? 15'(-{sel_d, 1'b0}) : 15'({sel_d, 1'b0});
    assign div_q  = math_rsp.quot[9:0];
    assign div_r  = math_rsp.rem[8:0];
    always_comb
    begin
        a_val = $signed({4'b0, div_q});
        b_val = div_r;
        if (d_neg)
        begin
            if (div_r == 9'd0)
            begin
                a_val = -$signed({4'b0, div_q});
            end
            else
            begin
                a_val = -$signed({4'b0, div_q}) - 14'sd1;
                b_val = unit16n - div_r;
            end
        end
    end

    assign rx_sum   = rx_reg + {1'b0, bx_reg};
    assign ry_sum   = ry_reg + {1'b0, by_reg};
    assign cx_carry = rx_sum >= {1'b0, unit16n};
    assign cy_carry = ry_sum >= {1'b0, unit16n};
    assign sx = qx_reg[13] ? 8'd0 : (qx_reg > $signed({6'b0, ew_m1})) ? ew_m1 : qx_reg[7:0];
    assign sy = qy_reg[13] ? 8'd0 : (qy_reg > $signed({6'b0, eh_m1})) ? eh_m1 : qy_reg[7:0];
    assign weight = n_reg - samp_cnt_reg;

    assign ch_sum = {1'b0, new_reg[chan_reg]} + {1'b0, math_rsp.quot[CHAN_W-1:0]};
    assign ch_sat = ((math_rsp.quot[DIVIDEND_W-1:CHAN_W] != '0) || ch_sum[CHAN_W])
                    ? {CHAN_W{1'b1}} : ch_sum[CHAN_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && opcode == OP_PROCESS)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:   state_next = ST_SQRT_D;
            ST_SQRT_D:   if (math_rsp.done) state_next = ST_SQRT_M;
            ST_SQRT_M:   if (math_rsp.done) state_next = ST_FALLOFF;
            ST_FALLOFF:
            begin
                if (d_reg >= denom_reg || math_rsp.done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:    state_next = ST_AMOUNT;
            ST_AMOUNT:   state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (n_reg != '0 && amount_reg > 17'(AMOUNT_MIN))
                begin
                    state_next = ST_STEP_X;
                end
                else
                begin
                    state_next = ST_PIX_RD;
                end
            end
            ST_STEP_X:   if (math_rsp.done) state_next = ST_STEP_Y;
            ST_STEP_Y:   if (math_rsp.done) state_next = ST_SAMP_RD;
            ST_SAMP_RD:  state_next = ST_SAMP_ACC;
            ST_SAMP_ACC:
            begin
                if (samp_cnt_reg == n_reg - N_W'(1))
                begin
                    state_next = ST_PIX_RD;
                end
                else
                begin
                    state_next = ST_SAMP_RD;
                end
            end
            ST_PIX_RD:   state_next = ST_PIX_WAIT;
            ST_PIX_WAIT: state_next = bright_reg ? ST_CH_MUL : ST_FINISH;
            ST_CH_MUL:   state_next = ST_CH_DIV;
            ST_CH_DIV:
            begin
                if (math_rsp.done)
                begin
                    state_next = (chan_reg == 2'd2) ? ST_FINISH : ST_CH_MUL;
                end
            end
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        ram_we    = 1'b0;
        ram_addr  = {pixel_y, pixel_x};
        ram_wdata = {blue_in, green_in, red_in};
        math_state = 1'b0;
        math_req.op = MATH_DIV;
        math_req.a  = '0;
        math_req.b  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_we = in_accept && opcode == OP_LOAD;
            end
            ST_SQRT_D:
            begin
                math_state  = 1'b1;
                math_req.op = MATH_SQRT;
                math_req.a  = {3'b0, sqd_reg};
            end
            ST_SQRT_M:
            begin
                math_state  = 1'b1;
                math_req.op = MATH_SQRT;
                math_req.a  = {5'b0, sqm_reg};
            end
            ST_FALLOFF:
            begin
                math_state = d_reg < denom_reg;
                math_req.a = {2'b0, d_reg, 16'b0};
                math_req.b = {2'b0, denom_reg};
            end
            ST_STEP_X, ST_STEP_Y:
            begin
                math_state = 1'b1;
                math_req.a = {17'b0, mag_2d};
                math_req.b = {7'b0, unit16n};
            end
            ST_SAMP_RD:
            begin
                ram_addr = {sy, sx};
            end
            ST_PIX_RD:
            begin
                ram_addr = {y_reg, x_reg};
            end
            ST_CH_DIV:
            begin
                math_state = 1'b1;
                math_req.a = {15'b0, prod_reg[32:16]};
                math_req.b = {8'b0, wtot};
            end
            ST_FINISH:
            begin
                ram_addr  = {y_reg, x_reg};
                ram_wdata = {new_reg[2], new_reg[1], new_reg[0]};
                ram_we    = out_free && bright_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        math_req.start = math_state && !launched_reg;
    end

    always_comb
    begin
        launched_next = launched_reg;
        if (math_req.start)
        begin
            launched_next = 1'b1;
        end
        else if (math_rsp.done)
        begin
            launched_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (state_reg == ST_FINISH && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cx_reg        <= 13'd2048;
            cy_reg        <= 13'd2048;
            int_reg       <= 7'd50;
            ray_reg       <= 9'd100;
            fw_reg        <= 9'd256;
            fh_reg        <= 9'd256;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_CENTER_X:  cx_reg  <= cfg_data;
                    REG_CENTER_Y:  cy_reg  <= cfg_data;
                    REG_INTENSITY: int_reg <= cfg_data[6:0];
                    REG_RAY_LEN:   ray_reg <= cfg_data[8:0];
                    REG_WIDTH:     fw_reg  <= cfg_data[8:0];
                    REG_HEIGHT:    fh_reg  <= cfg_data[8:0];
                    default:       cx_reg  <= cx_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                x_reg <= pixel_x;
                y_reg <= pixel_y;
            end
            ST_SQUARE:
            begin
                sqd_reg <= {1'b0, dx_sq} + {1'b0, dy_sq};
                sqm_reg <= {1'b0, 26'(cx_reg * cx_reg)} + {1'b0, 26'(cy_reg * cy_reg)};
                n_reg   <= n_val;
            end
            ST_SQRT_D:
            begin
                d_reg <= math_rsp.root[13:0];
            end
            ST_SQRT_M:
            begin
                denom_reg <= math_rsp.root[13:0] + 14'(CENTER_PAD);
            end
            ST_FALLOFF:
            begin
                if (d_reg >= denom_reg)
                begin
                    falloff_reg <= '0;
                end
                else
                begin
                    falloff_reg <= 17'h10000 - {1'b0, math_rsp.quot[15:0]};
                end
            end
            ST_SCALE:
            begin
                amt_num_reg <= 24'(falloff_reg * int_reg);
            end
            ST_AMOUNT:
            begin
                amount_reg <= amt_prod[RECIP_SHIFT +: 17];
            end
            ST_CHECK:
            begin
                bright_reg   <= n_reg != '0 && amount_reg > 17'(AMOUNT_MIN);
                samp_cnt_reg <= '0;
                sum_reg[0]   <= '0;
                sum_reg[1]   <= '0;
                sum_reg[2]   <= '0;
            end
            ST_STEP_X:
            begin
                ax_reg <= a_val;
                bx_reg <= b_val;
            end
            ST_STEP_Y:
            begin
                ay_reg <= a_val;
                by_reg <= b_val;
                // sample zero sits at the center itself
                qx_reg <= $signed({5'b0, cx_reg[12:4]});
                qy_reg <= $signed({5'b0, cy_reg[12:4]});
                rx_reg <= 10'(cx_reg[3:0] * n_reg);
                ry_reg <= 10'(cy_reg[3:0] * n_reg);
            end
            ST_SAMP_ACC:
            begin
                sum_reg[0] <= sum_reg[0] + 16'(ram_rdata[7:0] * weight);
                sum_reg[1] <= sum_reg[1] + 16'(ram_rdata[15:8] * weight);
                sum_reg[2] <= sum_reg[2] + 16'(ram_rdata[23:16] * weight);
                qx_reg <= qx_reg + ax_reg + $signed({13'b0, cx_carry});
                qy_reg <= qy_reg + ay_reg + $signed({13'b0, cy_carry});
                rx_reg <= cx_carry ? rx_sum - {1'b0, unit16n} : rx_sum;
                ry_reg <= cy_carry ? ry_sum - {1'b0, unit16n} : ry_sum;
                samp_cnt_reg <= samp_cnt_reg + N_W'(1);
            end
            ST_PIX_WAIT:
            begin
                new_reg[0] <= ram_rdata[7:0];
                new_reg[1] <= ram_rdata[15:8];
                new_reg[2] <= ram_rdata[23:16];
                chan_reg   <= 2'd0;
            end
            ST_CH_MUL:
            begin
                prod_reg <= 33'(sum_reg[chan_reg] * amount_reg);
            end
            ST_CH_DIV:
            begin
                if (math_rsp.done)
                begin
                    new_reg[chan_reg] <= ch_sat;
                    chan_reg          <= chan_reg + 2'd1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_x_reg      <= x_reg;
                    out_y_reg      <= y_reg;
                    out_pix_reg    <= {new_reg[2], new_reg[1], new_reg[0]};
                    out_bright_reg <= bright_reg;
                end
            end
            default:
            begin
                chan_reg <= chan_reg;
            end
        endcase
    end

    rlb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    rlb_math u_math (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (math_req),
        .rsp   (math_rsp)
    );

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign red_out    = out_pix_reg[7:0];
    assign green_out  = out_pix_reg[15:8];
    assign blue_out   = out_pix_reg[23:16];
    assign brightened = out_bright_reg;

`ifndef ASSERT_OFF
    a_done_after_launch: assert property (@(posedge clk) disable iff (!rst_n)
        math_rsp.done |-> launched_reg)
        else $error("math unit finished without a launch");

    a_sample_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAMP_ACC) |-> (samp_cnt_reg < n_reg))
        else $error("sample counter ran past the sample count");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result beat raised outside the finish step");

    a_writeback_only_bright: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_IDLE) |-> (state_reg == ST_FINISH && bright_reg))
        else $error("store written back for an unchanged pixel");
`endif

endmodule
